// ===== hw/rtl/knn_pkg.sv =====
// Shared constants, types and codes of the k-nearest-neighbor classifier.
package knn_pkg;

	localparam int STORE_DEPTH   = 128;
	localparam int MAX_NEIGHBORS = 15;
	localparam int FEATURE_BITS  = 12;
	localparam int NUM_FEATURES  = 4;
	localparam int NUM_CLASSES   = 3;
	localparam int DEFAULT_CLASS = 1;
	localparam int K_RESET       = 3;

	localparam int FIELD_W    = 12;
	localparam int LABEL_W    = 2;
	localparam int OP_W       = 2;
	localparam int K_W        = 4;
	localparam int IDX_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int COUNT_W    = $clog2(STORE_DEPTH + 1);
	localparam int SLOT_W     = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int VOTE_W     = $clog2(MAX_NEIGHBORS + 1);
	localparam int DIST_W     = 2 * FEATURE_BITS + 2;
	localparam int FSEL_W     = $clog2(NUM_FEATURES);
	localparam int FCNT_W     = $clog2(NUM_FEATURES + 1);
	localparam int ENTRY_W    = NUM_FEATURES * FEATURE_BITS + LABEL_W;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 8;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DIFF,
		S_INSERT,
		S_VOTE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clr;
		logic step;
	} dist_ctl_t;

endpackage

// ===== hw/rtl/knn_dist.sv =====
// Squared distance unit: one feature difference squared and accumulated per step.
module knn_dist (
	input  logic                                clk,
	input  logic                                arst_n,
	input  knn_pkg::dist_ctl_t                  ctl,
	input  logic [knn_pkg::FEATURE_BITS-1:0]    a,
	input  logic [knn_pkg::FEATURE_BITS-1:0]    b,
	output logic [knn_pkg::DIST_W-1:0]          dist_sum
);

	logic [knn_pkg::FEATURE_BITS-1:0]   diff;
	logic [2*knn_pkg::FEATURE_BITS-1:0] prod_s1;
	logic                               pv_s1;
	logic [knn_pkg::DIST_W-1:0]         acc_q;

	assign diff = (a >= b) ? (a - b) : (b - a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= ctl.step;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= diff * diff;
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + knn_pkg::DIST_W'(prod_s1);
		end
	end

	assign dist_sum = acc_q;

endmodule

// ===== hw/rtl/knn_classifier.sv =====
// Top level of the k-nearest-neighbor classifier: sample store, sequencer, neighbor list, vote.
//
//  channel  dir  signals                          carries
//  s_       in   s_tvalid s_tready s_tdata s_tuser  load / query / clear requests
//  m_       out  m_tvalid m_tready m_tdata          one prediction per query
//  cfg_     in   cfg_valid cfg_ready cfg_data       neighbor count k
//
//  Load, clear and unknown ops complete as they are accepted. A query scans the N stored
//  samples (none when k is zero): each sample is one store read, four passes through the
//  single squaring multiplier plus a drain, and one list insert; a vote over the list follows.
//  A finished prediction sits in the output register; a next query that finishes
//  before it is taken waits for it. Reset empties the store and sets k to 3.
module knn_classifier (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// feature_0, feature_1, feature_2, feature_3, class_label, zero pad
	input  logic [knn_pkg::IN_DATA_W-1:0]   s_tdata,
	// op
	input  logic [knn_pkg::OP_W-1:0]        s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// predicted_class, winning_votes, zero pad
	output logic [knn_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [knn_pkg::K_W-1:0]         cfg_data
);

	knn_pkg::state_t state_q, state_d;

	logic [knn_pkg::ENTRY_W-1:0]      mem [knn_pkg::STORE_DEPTH];
	logic [knn_pkg::ENTRY_W-1:0]      mem_q;
	logic [knn_pkg::COUNT_W-1:0]      count_q;
	logic [knn_pkg::K_W-1:0]          k_q;
	logic [knn_pkg::VOTE_W-1:0]       kq_q;
	logic [knn_pkg::VOTE_W-1:0]       kcap;
	logic [knn_pkg::COUNT_W-1:0]      idx_q;
	logic [knn_pkg::FCNT_W-1:0]       fcnt_q;
	logic [knn_pkg::SLOT_W-1:0]       vslot_q;

	logic [knn_pkg::FEATURE_BITS-1:0] qf_q [knn_pkg::NUM_FEATURES];
	logic [knn_pkg::FEATURE_BITS-1:0] in_feat [knn_pkg::NUM_FEATURES];
	logic [knn_pkg::FEATURE_BITS-1:0] mem_feat [knn_pkg::NUM_FEATURES];
	logic [knn_pkg::LABEL_W-1:0]      in_label;
	logic [knn_pkg::LABEL_W-1:0]      mem_label;

	logic [knn_pkg::DIST_W-1:0]       dist_q [knn_pkg::MAX_NEIGHBORS];
	logic [knn_pkg::LABEL_W-1:0]      lab_q [knn_pkg::MAX_NEIGHBORS];
	logic [knn_pkg::MAX_NEIGHBORS-1:0] vld_q;
	logic [knn_pkg::DIST_W-1:0]       dist_n [knn_pkg::MAX_NEIGHBORS];
	logic [knn_pkg::LABEL_W-1:0]      lab_n [knn_pkg::MAX_NEIGHBORS];
	logic [knn_pkg::MAX_NEIGHBORS-1:0] vld_n;
	logic [knn_pkg::MAX_NEIGHBORS-1:0] lt;

	logic [knn_pkg::VOTE_W-1:0]       votes_q [1:knn_pkg::NUM_CLASSES];
	logic [knn_pkg::LABEL_W-1:0]      pred;
	logic [knn_pkg::VOTE_W-1:0]       top_votes;

	logic [knn_pkg::DIST_W-1:0]       dist_w;
	knn_pkg::dist_ctl_t               dctl;
	logic [knn_pkg::FEATURE_BITS-1:0] dist_a;
	logic [knn_pkg::FEATURE_BITS-1:0] dist_b;

	logic                             m_tvalid_q;
	logic [knn_pkg::OUT_DATA_W-1:0]   m_tdata_q;
	logic                             in_acc;
	logic                             out_load;
	logic                             scan_end;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign in_acc    = s_tvalid && s_tready;

	always_comb begin
		for (int f = 0; f < knn_pkg::NUM_FEATURES; f++) begin
			in_feat[f]  = s_tdata[f*knn_pkg::FIELD_W +: knn_pkg::FEATURE_BITS];
			mem_feat[f] = mem_q[f*knn_pkg::FEATURE_BITS +: knn_pkg::FEATURE_BITS];
		end
		in_label  = s_tdata[knn_pkg::NUM_FEATURES*knn_pkg::FIELD_W +: knn_pkg::LABEL_W];
		mem_label = mem_q[knn_pkg::NUM_FEATURES*knn_pkg::FEATURE_BITS +: knn_pkg::LABEL_W];
	end

	assign kcap = (int'(k_q) > knn_pkg::MAX_NEIGHBORS) ? knn_pkg::VOTE_W'(knn_pkg::MAX_NEIGHBORS)
	                                                   : knn_pkg::VOTE_W'(k_q);
	assign scan_end = (idx_q == count_q) || (kq_q == '0);

	assign dist_a = qf_q[fcnt_q[knn_pkg::FSEL_W-1:0]];
	assign dist_b = mem_feat[fcnt_q[knn_pkg::FSEL_W-1:0]];

	knn_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dctl),
		.a        (dist_a),
		.b        (dist_b),
		.dist_sum (dist_w)
	);

	// sequencer
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		dctl      = '0;
		out_load  = 1'b0;
		unique case (state_q)
			knn_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser == knn_pkg::OP_QUERY) begin
					state_d = knn_pkg::S_SCAN;
				end
			end
			knn_pkg::S_SCAN: begin
				dctl.clr = 1'b1;
				state_d  = scan_end ? knn_pkg::S_VOTE : knn_pkg::S_DIFF;
			end
			knn_pkg::S_DIFF: begin
				dctl.step = (int'(fcnt_q) < knn_pkg::NUM_FEATURES);
				if (int'(fcnt_q) == knn_pkg::NUM_FEATURES) begin
					state_d = knn_pkg::S_INSERT;
				end
			end
			knn_pkg::S_INSERT: begin
				state_d = knn_pkg::S_SCAN;
			end
			knn_pkg::S_VOTE: begin
				if (int'(vslot_q) == knn_pkg::MAX_NEIGHBORS - 1) begin
					state_d = knn_pkg::S_DONE;
				end
			end
			knn_pkg::S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = knn_pkg::S_IDLE;
				end
			end
			default: state_d = knn_pkg::S_IDLE;
		endcase
	end

	// sorted insert: strict compare keeps the lower store index first on equal distance
	always_comb begin
		for (int j = 0; j < knn_pkg::MAX_NEIGHBORS; j++) begin
			lt[j] = !vld_q[j] || (dist_w < dist_q[j]);
		end
		for (int j = 0; j < knn_pkg::MAX_NEIGHBORS; j++) begin
			dist_n[j] = dist_q[j];
			lab_n[j]  = lab_q[j];
			vld_n[j]  = vld_q[j];
			if (j < int'(kq_q) && lt[j]) begin
				if (j == 0) begin
					dist_n[j] = dist_w;
					lab_n[j]  = mem_label;
					vld_n[j]  = 1'b1;
				end else if (!lt[j-1]) begin
					dist_n[j] = dist_w;
					lab_n[j]  = mem_label;
					vld_n[j]  = 1'b1;
				end else begin
					dist_n[j] = dist_q[j-1];
					lab_n[j]  = lab_q[j-1];
					vld_n[j]  = vld_q[j-1];
				end
			end
		end
	end

	always_comb begin
		pred      = knn_pkg::LABEL_W'(knn_pkg::DEFAULT_CLASS);
		top_votes = '0;
		for (int c = 1; c <= knn_pkg::NUM_CLASSES; c++) begin
			if (votes_q[c] > top_votes) begin
				top_votes = votes_q[c];
				pred      = knn_pkg::LABEL_W'(c);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= knn_pkg::S_IDLE;
			count_q    <= '0;
			k_q        <= knn_pkg::K_W'(knn_pkg::K_RESET);
			kq_q       <= '0;
			idx_q      <= '0;
			fcnt_q     <= '0;
			vslot_q    <= '0;
			vld_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				k_q <= cfg_data;
			end
			if (in_acc) begin
				unique case (s_tuser)
					knn_pkg::OP_LOAD: begin
						if (int'(count_q) < knn_pkg::STORE_DEPTH) begin
							count_q <= count_q + 1'b1;
						end
					end
					knn_pkg::OP_QUERY: begin
						kq_q  <= kcap;
						idx_q <= '0;
						vld_q <= '0;
					end
					knn_pkg::OP_CLEAR: begin
						count_q <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == knn_pkg::S_SCAN) begin
				fcnt_q  <= '0;
				vslot_q <= '0;
			end
			if (state_q == knn_pkg::S_DIFF) begin
				fcnt_q <= fcnt_q + 1'b1;
			end
			if (state_q == knn_pkg::S_INSERT) begin
				vld_q <= vld_n;
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == knn_pkg::S_VOTE) begin
				vslot_q <= vslot_q + 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == knn_pkg::OP_LOAD && int'(count_q) < knn_pkg::STORE_DEPTH) begin
			mem[count_q[knn_pkg::IDX_W-1:0]] <= {in_label, in_feat[3], in_feat[2], in_feat[1],
			                                     in_feat[0]};
		end
		if (state_q == knn_pkg::S_SCAN) begin
			mem_q <= mem[idx_q[knn_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int f = 0; f < knn_pkg::NUM_FEATURES; f++) begin
				qf_q[f] <= in_feat[f];
			end
			for (int c = 1; c <= knn_pkg::NUM_CLASSES; c++) begin
				votes_q[c] <= '0;
			end
		end
		if (state_q == knn_pkg::S_INSERT) begin
			for (int j = 0; j < knn_pkg::MAX_NEIGHBORS; j++) begin
				dist_q[j] <= dist_n[j];
				lab_q[j]  <= lab_n[j];
			end
		end
		if (state_q == knn_pkg::S_VOTE && vld_q[vslot_q] && lab_q[vslot_q] != '0) begin
			votes_q[lab_q[vslot_q]] <= votes_q[lab_q[vslot_q]] + 1'b1;
		end
		if (out_load) begin
			m_tdata_q <= knn_pkg::OUT_DATA_W'({4'(top_votes), pred});
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= knn_pkg::STORE_DEPTH)
		else $error("stored count beyond store depth");

	a_list_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q & (vld_q + 1'b1)) == '0 && $countones(vld_q) <= int'(kq_q))
		else $error("neighbor list valid bits not a prefix of length k");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == knn_pkg::S_DIFF |-> idx_q < count_q)
		else $error("distance step on an entry beyond the store fill");

	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !out_load |=> !m_tvalid)
		else $error("taken result not retired");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid || m_tready))
		else $error("result register overwritten while full");

endmodule

// ===== bench/knn_classifier_tb.sv =====
// Self-checking testbench for the k-nearest-neighbor classifier: requests, predictions, k.
module knn_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [knn_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 8000;
	localparam int SETTLE_CYCLES  = 20;

	typedef logic [knn_pkg::NUM_FEATURES-1:0][knn_pkg::FEATURE_BITS-1:0] feat_vec_t;

	typedef struct packed {
		logic [knn_pkg::LABEL_W-1:0] cls;
		logic [knn_pkg::K_W-1:0]     votes;
	} prediction_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [knn_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic [knn_pkg::OP_W-1:0]       s_tuser = knn_pkg::OP_LOAD;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [knn_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [knn_pkg::K_W-1:0]        cfg_data = '0;

	// shadow of the block's store and k
	feat_vec_t                   store_feat [knn_pkg::STORE_DEPTH];
	logic [knn_pkg::LABEL_W-1:0] store_label [knn_pkg::STORE_DEPTH];
	int                          store_count = 0;
	logic [knn_pkg::K_W-1:0]     model_k = knn_pkg::K_W'(knn_pkg::K_RESET);

	prediction_t predictions_due [$];
	prediction_t due_pred;
	int          mismatches = 0;
	int          send_burst = 0;
	int          ready_hold = 0;
	int          quiet_cycles = 0;

	knn_classifier DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic prediction_t predict_class(input feat_vec_t q);
		logic [knn_pkg::DIST_W-1:0]       near_dist [knn_pkg::MAX_NEIGHBORS];
		logic [knn_pkg::LABEL_W-1:0]      near_label [knn_pkg::MAX_NEIGHBORS];
		logic [knn_pkg::DIST_W-1:0]       sq_dist;
		logic [knn_pkg::FEATURE_BITS-1:0] diff;
		int                               votes [knn_pkg::NUM_CLASSES+1];
		int                               k_eff, held, pos, i, f, c, best;
		prediction_t                      p;
		k_eff = (model_k > knn_pkg::MAX_NEIGHBORS) ? knn_pkg::MAX_NEIGHBORS : int'(model_k);
		held = 0;
		for (i = 0; i < store_count && k_eff > 0; i++) begin
			sq_dist = '0;
			for (f = 0; f < knn_pkg::NUM_FEATURES; f++) begin
				diff = (q[f] >= store_feat[i][f]) ? q[f] - store_feat[i][f]
				                                  : store_feat[i][f] - q[f];
				sq_dist = sq_dist + knn_pkg::DIST_W'(diff) * knn_pkg::DIST_W'(diff);
			end
			// equal distance never displaces: lower index stays nearer
			if (held == k_eff && sq_dist >= near_dist[k_eff-1])
				continue;
			pos = (held < k_eff) ? held : k_eff - 1;
			while (pos > 0 && sq_dist < near_dist[pos-1]) begin
				near_dist[pos]  = near_dist[pos-1];
				near_label[pos] = near_label[pos-1];
				pos--;
			end
			near_dist[pos]  = sq_dist;
			near_label[pos] = store_label[i];
			if (held < k_eff)
				held++;
		end
		for (c = 0; c <= knn_pkg::NUM_CLASSES; c++)
			votes[c] = 0;
		for (i = 0; i < held; i++) begin
			if (near_label[i] != 0)
				votes[near_label[i]]++;
		end
		p.cls = knn_pkg::LABEL_W'(knn_pkg::DEFAULT_CLASS);
		best = 0;
		for (c = 1; c <= knn_pkg::NUM_CLASSES; c++) begin
			if (votes[c] > best) begin
				best  = votes[c];
				p.cls = knn_pkg::LABEL_W'(c);
			end
		end
		p.votes = knn_pkg::K_W'(best);
		return p;
	endfunction

	function automatic void apply_request(input logic [knn_pkg::OP_W-1:0] op,
	                                      input feat_vec_t feat,
	                                      input logic [knn_pkg::LABEL_W-1:0] label);
		case (op)
			knn_pkg::OP_LOAD: begin
				if (store_count < knn_pkg::STORE_DEPTH) begin
					store_feat[store_count]  = feat;
					store_label[store_count] = label;
					store_count++;
				end
			end
			knn_pkg::OP_QUERY: begin
				predictions_due.push_back(predict_class(feat));
			end
			knn_pkg::OP_CLEAR: begin
				store_count = 0;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int sender_gap();
		if (send_burst > 0) begin
			send_burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			send_burst = $urandom_range(10, 40);
			return 0;
		end
		return idle_length();
	endfunction

	function automatic feat_vec_t same_features(input logic [knn_pkg::FEATURE_BITS-1:0] v);
		feat_vec_t fv;
		int f;
		for (f = 0; f < knn_pkg::NUM_FEATURES; f++)
			fv[f] = v;
		return fv;
	endfunction

	// mostly clustered by label, some full range and some extremes
	function automatic feat_vec_t random_features(input logic [knn_pkg::LABEL_W-1:0] label);
		feat_vec_t fv;
		int f, mode;
		mode = $urandom_range(0, 9);
		for (f = 0; f < knn_pkg::NUM_FEATURES; f++) begin
			if (mode == 0)
				fv[f] = $urandom_range(0, 1) ? '1 : '0;
			else if (mode < 4)
				fv[f] = knn_pkg::FEATURE_BITS'($urandom_range(0, 4095));
			else
				fv[f] = knn_pkg::FEATURE_BITS'(300 + 1000 * label + $urandom_range(0, 255));
		end
		return fv;
	endfunction

	task automatic send_request(input logic [knn_pkg::OP_W-1:0] op, input feat_vec_t feat,
	                            input logic [knn_pkg::LABEL_W-1:0] label);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(knn_pkg::IN_DATA_W-knn_pkg::ENTRY_W){1'b0}}, label, feat};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_request(op, feat, label);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (predictions_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_neighbor_count(input logic [knn_pkg::K_W-1:0] k);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= k;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		model_k = k;
	endtask

	// empty store, unused op, extremes of features, k at reset
	task automatic test_basic_ops();
		send_request(knn_pkg::OP_QUERY, random_features(1), 2'd3);
		send_request(OP_UNUSED, random_features(2), 2'd1);
		send_request(knn_pkg::OP_CLEAR, same_features('1), 2'd2);
		send_request(knn_pkg::OP_LOAD, same_features('1), 2'd3);
		send_request(knn_pkg::OP_LOAD, same_features('0), 2'd0);
		send_request(knn_pkg::OP_LOAD, same_features(12'hAAA), 2'd1);
		send_request(knn_pkg::OP_LOAD, same_features(12'h555), 2'd2);
		send_request(knn_pkg::OP_QUERY, same_features('0), 2'd0);
		send_request(knn_pkg::OP_QUERY, same_features('1), 2'd1);
		send_request(OP_UNUSED, same_features('1), 2'd3);
		send_request(knn_pkg::OP_QUERY, same_features(12'h555), 2'd2);
	endtask

	// equal distances, label zero, vote ties, k of zero
	task automatic test_tie_breaks();
		feat_vec_t v;
		v = random_features(2);
		set_neighbor_count(4'd1);
		send_request(knn_pkg::OP_CLEAR, v, 2'd0);
		send_request(knn_pkg::OP_LOAD, v, 2'd2);
		send_request(knn_pkg::OP_LOAD, v, 2'd3);
		send_request(knn_pkg::OP_QUERY, v, 2'd0);
		send_request(knn_pkg::OP_CLEAR, v, 2'd1);
		send_request(knn_pkg::OP_LOAD, v, 2'd0);
		send_request(knn_pkg::OP_LOAD, v, 2'd3);
		send_request(knn_pkg::OP_QUERY, v, 2'd3);
		set_neighbor_count(4'd2);
		send_request(knn_pkg::OP_QUERY, v, 2'd0);
		send_request(knn_pkg::OP_CLEAR, v, 2'd0);
		send_request(knn_pkg::OP_LOAD, v, 2'd3);
		send_request(knn_pkg::OP_LOAD, v, 2'd2);
		send_request(knn_pkg::OP_QUERY, v, 2'd1);
		set_neighbor_count(4'd0);
		send_request(knn_pkg::OP_QUERY, v, 2'd2);
	endtask

	// fill past capacity, extra loads are dropped
	task automatic test_store_full();
		logic [knn_pkg::LABEL_W-1:0] label;
		int i;
		set_neighbor_count(4'd15);
		send_request(knn_pkg::OP_CLEAR, random_features(0), 2'd0);
		for (i = 0; i < knn_pkg::STORE_DEPTH + 8; i++) begin
			label = knn_pkg::LABEL_W'($urandom_range(0, 3));
			send_request(knn_pkg::OP_LOAD, random_features(label), label);
		end
		for (i = 0; i < 4; i++)
			send_request(knn_pkg::OP_QUERY,
			             random_features(knn_pkg::LABEL_W'($urandom_range(1, 3))),
			             knn_pkg::LABEL_W'($urandom_range(0, 3)));
		send_request(knn_pkg::OP_QUERY, same_features('0), 2'd0);
		send_request(knn_pkg::OP_QUERY, same_features('1), 2'd3);
	endtask

	task automatic test_random_traffic();
		logic [knn_pkg::K_W-1:0]     phase_k [5];
		logic [knn_pkg::LABEL_W-1:0] label;
		feat_vec_t                   last_load;
		feat_vec_t                   fv;
		int                          phase, i, r;
		phase_k[0] = 4'd15;
		phase_k[1] = knn_pkg::K_W'($urandom_range(2, 14));
		phase_k[2] = 4'd1;
		phase_k[3] = knn_pkg::K_W'($urandom_range(2, 14));
		phase_k[4] = 4'd0;
		last_load = same_features('0);
		for (phase = 0; phase < 5; phase++) begin
			set_neighbor_count(phase_k[phase]);
			send_request(knn_pkg::OP_CLEAR, random_features(0), 2'd0);
			for (i = 0; i < 66; i++) begin
				r = $urandom_range(0, 99);
				label = knn_pkg::LABEL_W'($urandom_range(0, 3));
				fv = ($urandom_range(0, 9) == 0) ? last_load : random_features(label);
				if (r < 52) begin
					send_request(knn_pkg::OP_LOAD, fv, label);
					last_load = fv;
				end else if (r < 90) begin
					send_request(knn_pkg::OP_QUERY, fv, label);
				end else if (r < 95) begin
					send_request(knn_pkg::OP_CLEAR, fv, label);
				end else begin
					send_request(OP_UNUSED, fv, label);
				end
			end
		end
	endtask

	// result sink with stall bursts and free-running stretches
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if ($urandom_range(0, 99) < 30) begin
			m_tready <= 1'b0;
			ready_hold = idle_length();
		end else begin
			m_tready <= 1'b1;
			ready_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
			                                         : $urandom_range(0, 3);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (predictions_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected prediction, expected none, actual class %0d votes %0d",
				         $time, m_tdata[1:0], m_tdata[5:2]);
			end else begin
				due_pred = predictions_due.pop_front();
				if (m_tdata[1:0] !== due_pred.cls) begin
					mismatches++;
					$display("%0t: predicted_class expected %0d actual %0d",
					         $time, due_pred.cls, m_tdata[1:0]);
				end
				if (m_tdata[5:2] !== due_pred.votes) begin
					mismatches++;
					$display("%0t: winning_votes expected %0d actual %0d",
					         $time, due_pred.votes, m_tdata[5:2]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** knn_classifier: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_tie_breaks();
		test_store_full();
		test_random_traffic();
		settle();
		if (mismatches == 0)
			$display("** knn_classifier: PASSED **");
		else
			$display("** knn_classifier: FAILED **");
		$finish;
	end

endmodule
